[rtl/lpmrt_pkg.sv]
// shared constants, types and helpers for the route table
package lpmrt_pkg;

    // table geometry
    localparam int MAX_ROUTES = 256;
    localparam int ADDR_W     = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CNT_W      = $clog2(MAX_ROUTES + 1);

    // field widths
    localparam int IP_W   = 32;
    localparam int LEN_W  = 6;
    localparam int PORT_W = 4;
    localparam int ENTRY_W = IP_W + LEN_W + IP_W + PORT_W;

    // longest legal prefix length
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(IP_W);

    // item command codes
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic write;
        logic rd_en;
        logic push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_lookup;
        logic empty;
        logic scan_last;
        logic out_free;
    } t_status;

    // clamp a prefix length to the address width
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        return (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

    // network mask for a prefix length of 0..32
    function automatic logic [IP_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        return ~({IP_W{1'b1}} >> len);
    endfunction

endpackage

[rtl/longest_prefix_match_route_table_core.sv]
// top level of the ipv4 longest prefix match route table
//
// One item is either an add or a lookup, and each item gives exactly one
// result. An add writes one route to the route ram unless the table is full;
// a lookup reads every stored route (none on an empty table), up to
// MAX_ROUTES. The route ram is scanned one entry per cycle through its
// single registered read port. Longer prefixes win, ties go to the route
// added first, a /0 route matches everything, and a route with a zero next
// hop returns the destination. A result waiting in the output register does
// not block the next item, only the delivery of the following result.
module longest_prefix_match_route_table_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [lpmrt_pkg::IP_W-1:0]    i_route_prefix,
    input  logic [lpmrt_pkg::LEN_W-1:0]   i_route_length,
    input  logic [lpmrt_pkg::IP_W-1:0]    i_route_hop,
    input  logic [lpmrt_pkg::PORT_W-1:0]  i_route_port,
    input  logic [lpmrt_pkg::IP_W-1:0]    i_dest_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [lpmrt_pkg::IP_W-1:0]    o_hop_out,
    output logic [lpmrt_pkg::PORT_W-1:0]  o_port_out,
    output logic                          o_table_full
);
    import lpmrt_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // controller
    lpmrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath
    lpmrt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_command      (i_command),
        .i_route_prefix (i_route_prefix),
        .i_route_length (i_route_length),
        .i_route_hop    (i_route_hop),
        .i_route_port   (i_route_port),
        .i_dest_address (i_dest_address),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_found        (o_found),
        .o_hop_out      (o_hop_out),
        .o_port_out     (o_port_out),
        .o_table_full   (o_table_full)
    );

    // a result never reports both a match and a rejected add
    a_found_excl_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_table_full))
        else $error("found and table_full both set");

    // after a result is pushed the block is ready for the next item
    a_push_then_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |=> !o_in_stall)
        else $error("not ready after result push");

    // an accepted item keeps the input stalled until its result is pushed
    a_load_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> o_in_stall)
        else $error("input not stalled while item in work");

    // a pushed result is presented on the next cycle
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |=> o_out_valid)
        else $error("pushed result not valid");

endmodule

[rtl/lpmrt_ram.sv]
// generic single write port, single read port ram with registered read
module lpmrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/lpmrt_ctrl.sv]
// sequencing state machine for adds and lookup scans
module lpmrt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lpmrt_pkg::t_status i_status,
    output lpmrt_pkg::t_cmd   o_cmd,
    output logic              o_in_stall
);
    import lpmrt_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_status.in_lookup) begin
                        n_state = ST_ADD;
                    end else if (i_status.empty) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_ADD: begin
                o_cmd.write = 1'b1;
                n_state     = ST_DONE;
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last entry read is compared in this cycle
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/lpmrt_dp.sv]
// route storage, match compare, best route tracking and output register
module lpmrt_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpmrt_pkg::t_cmd               i_cmd,
    output lpmrt_pkg::t_status            o_status,
    input  logic                          i_command,
    input  logic [lpmrt_pkg::IP_W-1:0]    i_route_prefix,
    input  logic [lpmrt_pkg::LEN_W-1:0]   i_route_length,
    input  logic [lpmrt_pkg::IP_W-1:0]    i_route_hop,
    input  logic [lpmrt_pkg::PORT_W-1:0]  i_route_port,
    input  logic [lpmrt_pkg::IP_W-1:0]    i_dest_address,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_found,
    output logic [lpmrt_pkg::IP_W-1:0]    o_hop_out,
    output logic [lpmrt_pkg::PORT_W-1:0]  o_port_out,
    output logic                          o_table_full
);
    import lpmrt_pkg::*;

    // latched item
    logic              r_lookup;
    logic [IP_W-1:0]   r_prefix;
    logic [LEN_W-1:0]  r_len;
    logic [IP_W-1:0]   r_hop;
    logic [PORT_W-1:0] r_port;
    logic [IP_W-1:0]   r_dest;

    // table fill and scan position
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_idx;
    logic              r_cmp_valid;
    logic              r_full_flag;
    logic              w_full;

    // best match so far
    logic              r_have;
    logic [LEN_W-1:0]  r_best_len;
    logic [IP_W-1:0]   r_best_hop;
    logic [PORT_W-1:0] r_best_port;

    // output register
    logic              r_out_valid;
    logic              r_found;
    logic [IP_W-1:0]   r_hop_out;
    logic [PORT_W-1:0] r_port_out;
    logic              r_table_full;

    // ram read side
    logic [ENTRY_W-1:0] w_rd_data;
    logic [IP_W-1:0]    w_e_prefix;
    logic [LEN_W-1:0]   w_e_len;
    logic [IP_W-1:0]    w_e_hop;
    logic [PORT_W-1:0]  w_e_port;
    logic               w_match;
    logic               w_better;
    logic               w_wr_en;

    assign w_full  = (r_count >= CNT_W'(MAX_ROUTES));
    assign w_wr_en = i_cmd.write && !w_full;

    // route storage, one entry per route
    lpmrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ROUTES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data ({r_prefix, r_len, r_hop, r_port}),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    assign {w_e_prefix, w_e_len, w_e_hop, w_e_port} = w_rd_data;

    // prefix match and longest length test
    assign w_match  = (((r_dest ^ w_e_prefix) & len_mask(w_e_len)) == '0);
    assign w_better = !r_have || (w_e_len > r_best_len);

    // status to controller
    always_comb begin
        o_status.in_lookup = (i_command == CMD_LOOKUP);
        o_status.empty     = (r_count == '0);
        o_status.scan_last = (CNT_W'(r_idx) == r_count - CNT_W'(1));
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lookup <= (i_command == CMD_LOOKUP);
            r_prefix <= i_route_prefix;
            r_len    <= sat_len(i_route_length);
            r_hop    <= i_route_hop;
            r_port   <= i_route_port;
            r_dest   <= i_dest_address;
        end
    end

    // entry count and add overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_wr_en) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_full_flag <= w_full;
        end
    end

    // scan index and compare stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_cmp_valid <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.rd_en) begin
                r_idx <= r_idx + ADDR_W'(1);
            end
        end
    end

    // best route tracking, earliest entry wins a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.load) begin
            r_have <= 1'b0;
        end else if (r_cmp_valid && w_match && w_better) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_valid && w_match && w_better) begin
            r_best_len  <= w_e_len;
            r_best_hop  <= w_e_hop;
            r_best_port <= w_e_port;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            if (!r_lookup) begin
                r_found      <= 1'b0;
                r_hop_out    <= '0;
                r_port_out   <= '0;
                r_table_full <= r_full_flag;
            end else if (r_have) begin
                r_found      <= 1'b1;
                // direct route returns the destination itself
                r_hop_out    <= (r_best_hop != '0) ? r_best_hop : r_dest;
                r_port_out   <= r_best_port;
                r_table_full <= 1'b0;
            end else begin
                r_found      <= 1'b0;
                r_hop_out    <= '0;
                r_port_out   <= '0;
                r_table_full <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_hop_out    = r_hop_out;
    assign o_port_out   = r_port_out;
    assign o_table_full = r_table_full;

endmodule

[tb/tb.sv]
// self-checking testbench for the longest prefix match route table core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpmrt_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES  = 2000;
    localparam int DRAIN_CYCLES = MAX_ROUTES + 16;
    localparam int CYCLE_LIMIT  = 3000000;

    // one input item as offered to the block
    typedef struct packed {
        logic              cmd;
        logic [IP_W-1:0]   prefix;
        logic [LEN_W-1:0]  length;
        logic [IP_W-1:0]   hop;
        logic [PORT_W-1:0] port;
        logic [IP_W-1:0]   dest;
    } t_route_item;

    // one result item
    typedef struct packed {
        logic              found;
        logic [IP_W-1:0]   hop;
        logic [PORT_W-1:0] port;
        logic              full;
    } t_route_result;

    // directed row: zero_result marks an all-zero result known up front
    typedef struct packed {
        t_route_item item;
        logic        zero_result;
    } t_stim_row;

    // which side idles how often
    typedef enum logic [1:0] {
        IDLE_RECV_HEAVY,
        IDLE_SEND_HEAVY,
        IDLE_OFF
    } t_idle_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_command = CMD_ADD;
    logic [IP_W-1:0]     i_route_prefix = '0;
    logic [LEN_W-1:0]    i_route_length = '0;
    logic [IP_W-1:0]     i_route_hop = '0;
    logic [PORT_W-1:0]   i_route_port = '0;
    logic [IP_W-1:0]     i_dest_address = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_found;
    logic [IP_W-1:0]     o_hop_out;
    logic [PORT_W-1:0]   o_port_out;
    logic                o_table_full;

    // predicted table contents, updated on each accepted add
    logic [IP_W-1:0]     stored_prefix [MAX_ROUTES];
    logic [LEN_W-1:0]    stored_len    [MAX_ROUTES];
    logic [IP_W-1:0]     stored_hop    [MAX_ROUTES];
    logic [PORT_W-1:0]   stored_port   [MAX_ROUTES];
    int                  stored_count = 0;

    t_route_result       pending_results [$];
    t_stim_row           directed_rows [$];
    t_idle_mode          idle_mode = IDLE_RECV_HEAVY;
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  hold_requests = 0;
    int                  holds_served = 0;
    int                  hold_left = 0;

    longest_prefix_match_route_table_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_route_prefix (i_route_prefix),
        .i_route_length (i_route_length),
        .i_route_hop    (i_route_hop),
        .i_route_port   (i_route_port),
        .i_dest_address (i_dest_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_hop_out      (o_hop_out),
        .o_port_out     (o_port_out),
        .o_table_full   (o_table_full)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // network mask for a stored length of 0..32
    function automatic logic [IP_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        if (len == 0)
            return '0;
        return {IP_W{1'b1}} << (IP_W - int'(len));
    endfunction

    // apply one accepted item to the predicted table and work out its result
    function automatic t_route_result resolve_item(input t_route_item it);
        t_route_result    r;
        logic [IP_W-1:0]  m;
        int               best;
        logic [LEN_W-1:0] best_len;
        r = '0;
        if (it.cmd == CMD_ADD) begin
            if (stored_count >= MAX_ROUTES) begin
                r.full = 1'b1;
            end else begin
                stored_prefix[stored_count] = it.prefix;
                stored_len[stored_count]    = (it.length > IP_W) ? LEN_W'(IP_W) : it.length;
                stored_hop[stored_count]    = it.hop;
                stored_port[stored_count]   = it.port;
                stored_count++;
            end
        end else begin
            best = -1;
            best_len = '0;
            // strictly longer wins, so the earliest of equal lengths stays
            for (int i = 0; i < stored_count; i++) begin
                m = prefix_mask(stored_len[i]);
                if (((it.dest ^ stored_prefix[i]) & m) == '0 &&
                    (best < 0 || stored_len[i] > best_len)) begin
                    best = i;
                    best_len = stored_len[i];
                end
            end
            if (best >= 0) begin
                r.found = 1'b1;
                r.hop   = (stored_hop[best] != '0) ? stored_hop[best] : it.dest;
                r.port  = stored_port[best];
            end
        end
        return r;
    endfunction

    // random item, mostly built around routes already in the table
    function automatic t_route_item make_random_item();
        t_route_item      it;
        int               pick;
        int               base;
        int               grown;
        logic [IP_W-1:0]  m;
        it.cmd    = ($urandom_range(0, 99) < 25) ? CMD_ADD : CMD_LOOKUP;
        it.prefix = $urandom;
        it.length = LEN_W'($urandom_range(8, 32));
        it.hop    = $urandom;
        it.port   = PORT_W'($urandom_range(0, 15));
        it.dest   = $urandom;
        base = (stored_count > 0) ? $urandom_range(0, stored_count - 1) : -1;
        m = (base >= 0) ? prefix_mask(stored_len[base]) : '0;
        pick = $urandom_range(0, 19);
        if (it.cmd == CMD_ADD) begin
            // default routes, oversized lengths, ties and nested routes
            if (pick == 0) begin
                it.length = '0;
            end else if (pick < 3) begin
                it.length = LEN_W'($urandom_range(33, 63));
            end else if (pick < 6 && base >= 0) begin
                it.prefix = stored_prefix[base];
                it.length = stored_len[base];
            end else if (pick < 12 && base >= 0) begin
                grown = int'(stored_len[base]) + $urandom_range(1, 8);
                it.length = LEN_W'((grown > IP_W) ? IP_W : grown);
                it.prefix = (stored_prefix[base] & m) | (it.prefix & ~m);
            end
            pick = $urandom_range(0, 15);
            if (pick < 4)
                it.hop = '0;
            else if (pick == 4)
                it.hop = '1;
        end else begin
            // destinations under a stored prefix, exact prefixes and noise
            if (pick < 14 && base >= 0)
                it.dest = (stored_prefix[base] & m) | (it.dest & ~m);
            else if (pick < 16 && base >= 0)
                it.dest = stored_prefix[base];
            else if (pick == 16)
                it.dest = '0;
            else if (pick == 17)
                it.dest = '1;
        end
        return it;
    endfunction

    function automatic t_stim_row add_row(input logic [IP_W-1:0] prefix,
                                          input logic [LEN_W-1:0] len,
                                          input logic [IP_W-1:0] hop,
                                          input logic [PORT_W-1:0] port);
        t_stim_row row;
        row.item = '{CMD_ADD, prefix, len, hop, port, ~prefix};
        row.zero_result = 1'b1;
        return row;
    endfunction

    function automatic t_stim_row look_row(input logic [IP_W-1:0] dest,
                                           input logic zero_result);
        t_stim_row row;
        row.item = '{CMD_LOOKUP, 32'($urandom), LEN_W'($urandom), 32'($urandom),
                     PORT_W'($urandom), dest};
        row.zero_result = zero_result;
        return row;
    endfunction

    function automatic logic sender_idles();
        case (idle_mode)
            IDLE_RECV_HEAVY: return $urandom_range(0, 99) < 12;
            IDLE_SEND_HEAVY: return $urandom_range(0, 99) < 81;
            default:         return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_idles();
        case (idle_mode)
            IDLE_RECV_HEAVY: return $urandom_range(0, 99) < 81;
            IDLE_SEND_HEAVY: return $urandom_range(0, 99) < 12;
            default:         return 1'b0;
        endcase
    endfunction

    // offer one item until accepted, then queue its expected result
    task automatic send_item(input t_route_item it, input logic zero_result);
        t_route_result predicted;
        while (sender_idles()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= it.cmd;
        i_route_prefix <= it.prefix;
        i_route_length <= it.length;
        i_route_hop    <= it.hop;
        i_route_port   <= it.port;
        i_dest_address <= it.dest;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = resolve_item(it);
        pending_results.push_back(zero_result ? t_route_result'('0) : predicted);
    endtask

    // stimulus: reset, directed rows, random items, drain
    initial begin
        // empty table lookups
        directed_rows.push_back(look_row(32'h0000_0000, 1'b1));
        directed_rows.push_back(look_row(32'hFFFF_FFFF, 1'b1));
        // nested routes, a default route and a tie at /8
        directed_rows.push_back(add_row(32'h0A00_0000, 6'd8,  32'h0A00_00FE, 4'd1));
        directed_rows.push_back(add_row(32'hFFFF_FFFF, 6'd0,  32'h0A0A_0A01, 4'd15));
        directed_rows.push_back(add_row(32'h0A01_0000, 6'd16, 32'h0000_0000, 4'd2));
        directed_rows.push_back(add_row(32'h0A01_0200, 6'd24, 32'h0A01_02FE, 4'd3));
        directed_rows.push_back(add_row(32'h0A01_0203, 6'd32, 32'hFFFF_FFFF, 4'd4));
        directed_rows.push_back(add_row(32'h0A01_0203, 6'd63, 32'h1234_5678, 4'd5));
        directed_rows.push_back(add_row(32'hC000_0000, 6'd2,  32'h8000_0001, 4'd8));
        directed_rows.push_back(add_row(32'h0A00_00FF, 6'd8,  32'h1111_1111, 4'd9));
        // host route wins, ties go to the earlier route
        directed_rows.push_back(look_row(32'h0A01_0203, 1'b0));
        directed_rows.push_back(look_row(32'h0A01_0204, 1'b0));
        // direct route returns the destination, then the tie at /8
        directed_rows.push_back(look_row(32'h0A01_FF01, 1'b0));
        directed_rows.push_back(look_row(32'h0AFF_FFFF, 1'b0));
        // default route and short prefix
        directed_rows.push_back(look_row(32'h0000_0000, 1'b0));
        directed_rows.push_back(look_row(32'hFFFF_FFFF, 1'b0));
        directed_rows.push_back(look_row(32'h7FFF_FFFF, 1'b0));
        // length above 32 is saturated to a host route
        directed_rows.push_back(add_row(32'h7F00_0000, 6'd33, 32'h0000_0000, 4'd0));
        directed_rows.push_back(look_row(32'h7F00_0000, 1'b0));
        directed_rows.push_back(look_row(32'h7F00_0001, 1'b0));
        directed_rows.push_back(add_row(32'h8000_0000, 6'd1,  32'hFFFF_FFFF, 4'd15));
        directed_rows.push_back(look_row(32'h8000_0000, 1'b0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].zero_result);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3)
                idle_mode <= IDLE_SEND_HEAVY;
            if (n == 2 * RANDOM_ITEMS / 3)
                idle_mode <= IDLE_OFF;
            // long receiver hold-off to back up the block
            if (n == 2 * RANDOM_ITEMS / 3 + 100)
                hold_requests <= hold_requests + 1;
            send_item(make_random_item(), 1'b0);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver stall: random idling, or a long hold-off on request
    always @(posedge i_clk) begin
        if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= receiver_idles();
        end
    end

    // compare each delivered result with the oldest prediction
    always @(posedge i_clk) begin
        t_route_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result found=%0b hop=%h port=%0d full=%0b",
                         $time, o_found, o_hop_out, o_port_out, o_table_full);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found) begin
                    $display("%0t: found expected %0b got %0b", $time, want.found, o_found);
                    error_count++;
                end
                if (o_hop_out !== want.hop) begin
                    $display("%0t: hop_out expected %h got %h", $time, want.hop, o_hop_out);
                    error_count++;
                end
                if (o_port_out !== want.port) begin
                    $display("%0t: port_out expected %0d got %0d",
                             $time, want.port, o_port_out);
                    error_count++;
                end
                if (o_table_full !== want.full) begin
                    $display("%0t: table_full expected %0b got %0b",
                             $time, want.full, o_table_full);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

[sim.f]
rtl/lpmrt_pkg.sv
rtl/lpmrt_ram.sv
rtl/lpmrt_ctrl.sv
rtl/lpmrt_dp.sv
rtl/longest_prefix_match_route_table_core.sv
tb/tb.sv
